### rtl/assert_macros.svh
// Assertion macros used by the top level of the vector magnitude normaliser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VMN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VMN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VMN_ASSERT(label, clk, rst, prop, msg)
`define VMN_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/vmn_pkg.sv
// Package with widths, codes and types of the vector magnitude normaliser.
`timescale 1ns / 1ps
`default_nettype none
package vmn_pkg;
   localparam int IDX_W         = 17;
   localparam int COMP_W        = 16;
   localparam int MAG_W         = 16;
   localparam int SCALED_W      = 24;
   localparam int GAIN_W        = 16;
   localparam int OP_W          = 2;
   localparam int CELLS_DEFAULT = 131072;
   localparam int REQ_DATA_W    = 72;
   localparam int RSP_DATA_W    = 56;
   localparam int ROOT_STEPS    = 16;
   localparam int DIV_STEPS     = 24;
   localparam int CNT_W         = $clog2(DIV_STEPS + 1);

   localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd256;
   localparam logic [MAG_W-1:0]    MAG_MAX    = 16'd56755;
   localparam logic [SCALED_W-1:0] SCALED_MAX = 24'hFFFFFF;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic              start;
      logic              is_root;
      logic [31:0]       operand;
      logic [MAG_W-1:0]  divisor;
      logic [MAG_W-1:0]  rem_init;
   } vmn_cmd_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [SCALED_W-1:0] result;
   } vmn_res_type;
endpackage
`default_nettype wire

### rtl/vmn_iter.sv
// Shared shift-and-subtract unit: square root two bits a step, division one bit a step.
`timescale 1ns / 1ps
`default_nettype none
module vmn_iter (
   input  wire                 clock,
   input  wire                 reset,
   input  vmn_pkg::vmn_cmd_type cmd,
   output vmn_pkg::vmn_res_type res
);
   import vmn_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                root_ff, root_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [17:0]         rem_ff, rem_in;
   logic [31:0]         src_ff, src_in;
   logic [SCALED_W-1:0] acc_ff, acc_in;
   logic [MAG_W-1:0]    div_ff, div_in;
   logic [19:0]         wide;
   logic [19:0]         trial;
   logic [19:0]         diff;
   logic                ge;

   always_comb begin
      if (root_ff) begin
         wide  = {rem_ff, src_ff[31:30]};
         trial = {2'b00, acc_ff[15:0], 2'b01};
      end else begin
         wide  = {1'b0, rem_ff, src_ff[31]};
         trial = {4'b0000, div_ff};
      end
      diff = wide - trial;
      ge   = (wide >= trial);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      acc_in  = acc_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         root_in = cmd.is_root;
         cnt_in  = cmd.is_root ? CNT_W'(ROOT_STEPS) : CNT_W'(DIV_STEPS);
         rem_in  = {2'b00, cmd.rem_init};
         src_in  = cmd.operand;
         acc_in  = '0;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[17:0] : wide[17:0];
         src_in = root_ff ? {src_ff[29:0], 2'b00} : {src_ff[30:0], 1'b0};
         acc_in = {acc_ff[SCALED_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      root_ff <= root_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      acc_ff  <= acc_in;
      div_ff  <= div_in;
   end

   assign res.busy   = busy_ff;
   assign res.done   = done_ff;
   assign res.result = acc_ff;
endmodule
`default_nettype wire

### rtl/vector_magnitude_normalizer_top.sv
// Top level of the vector magnitude normaliser: handshakes, sequencer, store and peak.
//
//  channel | ports                          | contents
//  --------+--------------------------------+---------------------------------------
//  request | req_tvalid req_tready req_tdata | cell_index, vel_x, vel_y, vel_z; op
//          | req_tuser                       | in tuser
//  result  | rsp_tvalid rsp_tready rsp_tdata | scaled_value, magnitude, peak
//  config  | csr_wr_en csr_wr_data           | brightness_gain
//
// Items run one at a time. A load squares and sums the components in the multiplier, runs
// sixteen root steps, collects the root and outputs it; a read forms the product, checks it,
// runs twenty-four division steps, collects and outputs; a read that saturates or meets a zero
// peak, and a clear or an unused op, output at once. Reset is synchronous, clears the peak and
// the control state and sets the gain to GAIN_RESET; the store is kept. The request side is
// not ready while an item is at work, and a result that finds the output register full waits.
`timescale 1ns / 1ps
`default_nettype none
module vector_magnitude_normalizer_top #(
   parameter int CELLS = vmn_pkg::CELLS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // cell_index[16:0], vel_x[32:17], vel_y[48:33], vel_z[64:49], zero[71:65]
   input  wire  [vmn_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[1:0]
   input  wire  [vmn_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // scaled_value[23:0], magnitude[39:24], peak[55:40]
   output logic [vmn_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire                                csr_wr_en,
   input  wire  [vmn_pkg::GAIN_W-1:0]         csr_wr_data
);
   import vmn_pkg::*;
   `include "assert_macros.svh"

   localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int AXW = (AW > IDX_W) ? AW : IDX_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_RD_MUL = 3'd2;
   localparam logic [2:0] ST_RD_CHK = 3'd3;
   localparam logic [2:0] ST_ENGINE = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic                  range_ff, range_in;
   logic [16:0]           abs_ff [3];
   logic [16:0]           abs_in [3];
   logic [1:0]            cnt_ff, cnt_in;
   logic [31:0]           mul_ff, mul_in;
   logic [31:0]           acc_ff, acc_in;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic [SCALED_W-1:0]   scaled_ff, scaled_in;
   logic [MAG_W-1:0]      peak_ff, peak_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [MAG_W-1:0]      mem_q_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic                  accept;
   logic                  mem_we;
   logic [IDX_W-1:0]      req_idx;
   logic [AXW-1:0]        req_idx_ext;
   logic                  req_range;
   logic [AW-1:0]         req_addr;
   logic [MAG_W-1:0]      mag_sel;
   logic [16:0]           mul_a, mul_b;
   logic [33:0]           mul_full;
   logic [MAG_W-1:0]      mem [CELLS];
   vmn_cmd_type           cmd;
   vmn_res_type           eng;

   function automatic logic [16:0] abs16(input logic [COMP_W-1:0] v);
      logic [16:0] r;
      if (v[COMP_W-1]) begin
         r = 17'h10000 - {1'b0, v};
      end else begin
         r = {1'b0, v};
      end
      return r;
   endfunction

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign req_idx     = req_tdata[IDX_W-1:0];
   assign req_idx_ext = AXW'(req_idx);
   assign req_range   = ({1'b0, req_idx_ext} < (AXW + 1)'(CELLS));
   assign req_addr    = req_idx_ext[AW-1:0];
   assign mag_sel     = range_ff ? mem_q_ff : '0;

   always_comb begin
      if (state_ff == ST_RD_MUL) begin
         mul_a = {1'b0, mag_sel};
         mul_b = {1'b0, gain_ff};
      end else begin
         mul_a = abs_ff[cnt_ff];
         mul_b = abs_ff[cnt_ff];
      end
      mul_full = mul_a * mul_b;
      mul_in   = mul_full[31:0];
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      range_in  = range_ff;
      abs_in    = abs_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mag_in    = mag_ff;
      scaled_in = scaled_ff;
      peak_in   = peak_ff;
      gain_in   = csr_wr_en ? csr_wr_data : gain_ff;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      cmd       = '0;
      cmd.divisor = peak_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               addr_in   = req_addr;
               range_in  = req_range;
               abs_in[0] = abs16(req_tdata[32:17]);
               abs_in[1] = abs16(req_tdata[48:33]);
               abs_in[2] = abs16(req_tdata[64:49]);
               cnt_in    = 2'd0;
               mag_in    = '0;
               scaled_in = '0;
               if (req_tuser == OP_LOAD) begin
                  state_in = ST_MUL;
               end else if (req_tuser == OP_READ) begin
                  state_in = ST_RD_MUL;
               end else begin
                  if (req_tuser == OP_CLEAR) begin
                     peak_in = '0;
                  end
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               acc_in = mul_ff;
            end else if (cnt_ff == 2'd2) begin
               acc_in = acc_ff + mul_ff;
            end else if (cnt_ff == 2'd3) begin
               cmd.start   = 1'b1;
               cmd.is_root = 1'b1;
               cmd.operand = acc_ff + mul_ff;
               state_in    = ST_ENGINE;
            end
         end
         ST_RD_MUL: begin
            mag_in   = mag_sel;
            state_in = ST_RD_CHK;
         end
         ST_RD_CHK: begin
            if (peak_ff == '0) begin
               scaled_in = '0;
               state_in  = ST_FIN;
            end else if (mul_ff[31:16] >= peak_ff) begin
               scaled_in = SCALED_MAX;
               state_in  = ST_FIN;
            end else begin
               cmd.start    = 1'b1;
               cmd.operand  = {mul_ff[15:0], 16'h0000};
               cmd.rem_init = mul_ff[31:16];
               state_in     = ST_ENGINE;
            end
         end
         ST_ENGINE: begin
            if (eng.done) begin
               state_in = ST_FIN;
               if (op_ff == OP_LOAD) begin
                  mag_in = eng.result[MAG_W-1:0];
                  if (range_ff) begin
                     mem_we = 1'b1;
                     if (eng.result[MAG_W-1:0] > peak_ff) begin
                        peak_in = eng.result[MAG_W-1:0];
                     end
                  end
               end else begin
                  scaled_in = eng.result;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_data_in  = rsp_load ? {peak_ff, mag_ff, scaled_ff} : rsp_data_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= eng.result[MAG_W-1:0];
      end
      mem_q_ff <= mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         peak_ff      <= '0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      range_ff    <= range_in;
      abs_ff      <= abs_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      scaled_ff   <= scaled_in;
      rsp_data_ff <= rsp_data_in;
   end

   vmn_iter u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (eng)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `VMN_ASSERT(a_busy_after_accept, clock, reset, accept |=> !req_tready, "ready after accept")
   `VMN_ASSERT(a_done_in_engine, clock, reset, eng.done |-> (state_ff == ST_ENGINE), "stray done")
   `VMN_ASSERT(a_peak_bound, clock, reset, peak_ff <= MAG_MAX, "peak above largest magnitude")
   `VMN_ASSERT(a_start_idle_unit, clock, reset, cmd.start |-> !eng.busy, "unit restarted while busy")
   `VMN_ASSERT(a_engine_runs, clock, reset, (state_ff == ST_ENGINE) |-> (eng.busy || eng.done),
               "engine state without work")
endmodule
`default_nettype wire
